// ===== hw/rtl/pcbi_pkg.sv =====
// Shared types, constants and tables of the pixel change burst injector.
// No dependencies; the design files but pcbi_ram refer to it by scoped names, the tests import it.
package pcbi_pkg;

    // Geometry limits and store sizes
    localparam int MAX_WIDTH   = 512;
    localparam int MAX_HEIGHT  = 512;
    localparam int MAX_STRIDE  = 16;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // Field and register widths
    localparam int PX_W     = 9;
    localparam int PIXEL_W  = 32;
    localparam int CFG_W    = 10;
    localparam int STRIDE_W = 5;
    localparam int GAIN_W   = 10;
    localparam int CIDX_W   = 3;
    localparam int CELL_W   = 8;

    // Reciprocal used for division by the stride
    localparam int RECIP_SHIFT = 18;
    localparam int RECIP_W     = RECIP_SHIFT + 1;

    localparam logic [PIXEL_W-1:0] SHADOW_RESET = 32'hFF000000;
    localparam logic [CELL_W-1:0]  CELL_MAX     = 8'hFF;

    // Register indexes of the configuration port
    localparam logic [CIDX_W-1:0] CFG_FRAME_WIDTH   = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_FRAME_HEIGHT  = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_SAMPLE_STRIDE = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_SAMPLED_WIDTH = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_GAIN_Q8       = 3'd4;

    typedef enum logic {
        KIND_UPDATE = 1'b0,
        KIND_DRAIN  = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_MUL,
        FS_ADDR
    } t_front_state;

    typedef enum logic [1:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_LOOK
    } t_back_state;

    // One classified item on its way from front to back
    typedef struct packed {
        t_kind                kind;
        logic                 oor;
        logic                 cell_ok;
        logic [ADDR_W-1:0]    si;
        logic [ADDR_W-1:0]    ci;
        logic [PIXEL_W-1:0]   pixel;
        logic [GAIN_W-1:0]    gain;
    } t_job;

    // Rounded-up reciprocal, ceil(2^RECIP_SHIFT / s), for strides 1 to 16
    function automatic logic [RECIP_W-1:0] recip(input logic [STRIDE_W-1:0] s);
        logic [RECIP_W-1:0] r;
        case (s)
            5'd1:    r = 19'd262144;
            5'd2:    r = 19'd131072;
            5'd3:    r = 19'd87382;
            5'd4:    r = 19'd65536;
            5'd5:    r = 19'd52429;
            5'd6:    r = 19'd43691;
            5'd7:    r = 19'd37450;
            5'd8:    r = 19'd32768;
            5'd9:    r = 19'd29128;
            5'd10:   r = 19'd26215;
            5'd11:   r = 19'd23832;
            5'd12:   r = 19'd21846;
            5'd13:   r = 19'd20165;
            5'd14:   r = 19'd18725;
            5'd15:   r = 19'd17477;
            5'd16:   r = 19'd16384;
            default: r = 19'd262144;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/pcbi_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pcbi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port; read data holds when not reading
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/pcbi_front.sv =====
// Front end: configuration registers, item intake, bound checks and address maths.
// Depends on pcbi_pkg.
module pcbi_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pcbi_pkg::CIDX_W-1:0]   i_cfg_index,
    input  logic [pcbi_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_hold,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_kind,
    input  logic [pcbi_pkg::PX_W-1:0]     i_pos_x,
    input  logic [pcbi_pkg::PX_W-1:0]     i_pos_y,
    input  logic [pcbi_pkg::PIXEL_W-1:0]  i_new_pixel,
    input  logic                          i_full,
    output logic                          o_push,
    output pcbi_pkg::t_job                o_job
);

    localparam int QX_W = pcbi_pkg::PX_W + pcbi_pkg::RECIP_W;
    localparam int HS_W = pcbi_pkg::CFG_W + 1;
    localparam int QH_W = HS_W + pcbi_pkg::RECIP_W;
    localparam int SI_W = pcbi_pkg::PX_W + pcbi_pkg::CFG_W + 1;

    pcbi_pkg::t_front_state r_state, n_state;

    logic [pcbi_pkg::CFG_W-1:0]    r_frame_width, r_frame_height, r_sampled_width, r_gain;
    logic [pcbi_pkg::STRIDE_W-1:0] r_stride;

    logic                          r_kind;
    logic [pcbi_pkg::PX_W-1:0]     r_px, r_py;
    logic [pcbi_pkg::PIXEL_W-1:0]  r_pixel;
    logic [QX_W-1:0]               r_qx, r_qy;
    logic [QH_W-1:0]               r_qh;
    logic [SI_W-1:0]               r_si;

    logic [pcbi_pkg::CFG_W-1:0]    w_eff, h_eff, sw_eff;
    logic [pcbi_pkg::STRIDE_W-1:0] s_eff;
    logic [pcbi_pkg::RECIP_W-1:0]  rs;
    logic [HS_W-1:0]               h_plus;
    logic [pcbi_pkg::PX_W-1:0]     cx, cy;
    logic [HS_W-1:0]               sh_rows;
    logic                          cell_ok, upd_ok, drn_ok;
    logic [pcbi_pkg::PX_W-1:0]     row_sel, col_sel;
    logic [SI_W-1:0]               ci_full;
    logic                          accept;

    function automatic logic [pcbi_pkg::CFG_W-1:0] CFG_W_EXT(
        input logic [pcbi_pkg::PX_W-1:0] v
    );
        return pcbi_pkg::CFG_W'(v);
    endfunction

    // Clamp the geometry to the store limits
    always_comb begin
        w_eff  = (r_frame_width > pcbi_pkg::CFG_W'(pcbi_pkg::MAX_WIDTH))
               ? pcbi_pkg::CFG_W'(pcbi_pkg::MAX_WIDTH) : r_frame_width;
        h_eff  = (r_frame_height > pcbi_pkg::CFG_W'(pcbi_pkg::MAX_HEIGHT))
               ? pcbi_pkg::CFG_W'(pcbi_pkg::MAX_HEIGHT) : r_frame_height;
        sw_eff = (r_sampled_width > pcbi_pkg::CFG_W'(pcbi_pkg::MAX_WIDTH))
               ? pcbi_pkg::CFG_W'(pcbi_pkg::MAX_WIDTH) : r_sampled_width;
        if (r_stride == '0) begin
            s_eff = pcbi_pkg::STRIDE_W'(1);
        end else if (r_stride > pcbi_pkg::STRIDE_W'(pcbi_pkg::MAX_STRIDE)) begin
            s_eff = pcbi_pkg::STRIDE_W'(pcbi_pkg::MAX_STRIDE);
        end else begin
            s_eff = r_stride;
        end
        rs     = pcbi_pkg::recip(s_eff);
        h_plus = HS_W'(h_eff) + HS_W'(s_eff) - HS_W'(1);
    end

    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != pcbi_pkg::FS_IDLE) || i_hold;

    // Quotients from the reciprocal products
    always_comb begin
        cx      = r_qx[pcbi_pkg::RECIP_SHIFT +: pcbi_pkg::PX_W];
        cy      = r_qy[pcbi_pkg::RECIP_SHIFT +: pcbi_pkg::PX_W];
        sh_rows = r_qh[pcbi_pkg::RECIP_SHIFT +: HS_W];
        cell_ok = CFG_W_EXT(cx) < sw_eff;
        upd_ok  = (CFG_W_EXT(r_px) < w_eff) && (CFG_W_EXT(r_py) < h_eff);
        drn_ok  = (CFG_W_EXT(r_px) < sw_eff) && (HS_W'(r_py) < sh_rows);
        row_sel = (r_kind == pcbi_pkg::KIND_DRAIN) ? r_py : cy;
        col_sel = (r_kind == pcbi_pkg::KIND_DRAIN) ? r_px : cx;
        ci_full = SI_W'(row_sel) * SI_W'(sw_eff) + SI_W'(col_sel);
    end

    // Build the job for the queue
    always_comb begin
        o_job.kind    = pcbi_pkg::t_kind'(r_kind);
        o_job.oor     = (r_kind == pcbi_pkg::KIND_DRAIN) ? !drn_ok : !upd_ok;
        o_job.cell_ok = cell_ok;
        o_job.si      = r_si[pcbi_pkg::ADDR_W-1:0];
        o_job.ci      = ((r_kind == pcbi_pkg::KIND_DRAIN) || cell_ok)
                      ? ci_full[pcbi_pkg::ADDR_W-1:0] : '0;
        o_job.pixel   = r_pixel;
        o_job.gain    = r_gain;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pcbi_pkg::FS_IDLE: if (accept) n_state = pcbi_pkg::FS_MUL;
            pcbi_pkg::FS_MUL:  n_state = pcbi_pkg::FS_ADDR;
            pcbi_pkg::FS_ADDR: if (!i_full) n_state = pcbi_pkg::FS_IDLE;
            default:           n_state = pcbi_pkg::FS_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        case (r_state)
            pcbi_pkg::FS_ADDR: o_push = !i_full;
            default:           o_push = 1'b0;
        endcase
    end

    // Control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= pcbi_pkg::FS_IDLE;
            r_frame_width   <= pcbi_pkg::CFG_W'(512);
            r_frame_height  <= pcbi_pkg::CFG_W'(512);
            r_stride        <= pcbi_pkg::STRIDE_W'(1);
            r_sampled_width <= pcbi_pkg::CFG_W'(512);
            r_gain          <= pcbi_pkg::CFG_W'(256);
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    pcbi_pkg::CFG_FRAME_WIDTH:   r_frame_width   <= i_cfg_data;
                    pcbi_pkg::CFG_FRAME_HEIGHT:  r_frame_height  <= i_cfg_data;
                    pcbi_pkg::CFG_SAMPLE_STRIDE: r_stride        <= i_cfg_data[pcbi_pkg::STRIDE_W-1:0];
                    pcbi_pkg::CFG_SAMPLED_WIDTH: r_sampled_width <= i_cfg_data;
                    pcbi_pkg::CFG_GAIN_Q8:       r_gain          <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Capture the item, then form the products
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind  <= i_kind;
            r_px    <= i_pos_x;
            r_py    <= i_pos_y;
            r_pixel <= i_new_pixel;
        end
        if (r_state == pcbi_pkg::FS_MUL) begin
            r_qx <= QX_W'(r_px) * QX_W'(rs);
            r_qy <= QX_W'(r_py) * QX_W'(rs);
            r_qh <= QH_W'(h_plus) * QH_W'(rs);
            r_si <= SI_W'(r_py) * SI_W'(w_eff) + SI_W'(r_px);
        end
    end

endmodule

// ===== hw/rtl/pcbi_fifo.sv =====
// Two-entry job queue between front and back.
// Depends on pcbi_pkg.
module pcbi_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pcbi_pkg::t_job i_job,
    input  logic           i_pop,
    output pcbi_pkg::t_job o_head,
    output logic           o_empty,
    output logic           o_full
);

    pcbi_pkg::t_job r_slot [2];
    logic           r_wptr, r_rptr;
    logic [1:0]     r_count;

    assign o_head  = r_slot[r_rptr];
    assign o_empty = (r_count == 2'd0);
    assign o_full  = (r_count == 2'd2);

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wptr <= !r_wptr;
            if (i_pop)  r_rptr <= !r_rptr;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Store pushed words
    always_ff @(posedge i_clk) begin
        if (i_push) r_slot[r_wptr] <= i_job;
    end

endmodule

// ===== hw/rtl/pcbi_back.sv =====
// Back end: clearing pass, shadow and cell stores, burst maths and result register.
// Depends on pcbi_pkg and pcbi_ram.
module pcbi_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pcbi_pkg::t_job               i_head,
    input  logic                         i_empty,
    output logic                         o_pop,
    output logic                         o_clearing,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_changed,
    output logic [pcbi_pkg::CELL_W-1:0]  o_burst,
    output logic [pcbi_pkg::CELL_W-1:0]  o_cell_value,
    output logic                         o_out_of_range
);

    localparam int PROD_W = pcbi_pkg::CELL_W + pcbi_pkg::GAIN_W;

    pcbi_pkg::t_back_state r_state, n_state;

    logic [pcbi_pkg::ADDR_W-1:0] r_clr_addr;
    pcbi_pkg::t_job              r_job;

    logic                        r_o_valid, r_o_changed, r_o_oor;
    logic [pcbi_pkg::CELL_W-1:0] r_o_burst, r_o_cell;

    logic [pcbi_pkg::PIXEL_W-1:0] shadow_rdata, shadow_wdata;
    logic [pcbi_pkg::CELL_W-1:0]  cell_rdata, cell_wdata;
    logic [pcbi_pkg::ADDR_W-1:0]  shadow_waddr, cell_waddr;
    logic                         shadow_we, cell_we, rd_en;

    logic                        out_free, finish;
    logic                        diff_seen;
    logic [pcbi_pkg::CELL_W-1:0] dr, dg, db, dmax;
    logic [PROD_W-1:0]           prod;
    logic [PROD_W-9:0]           prod_sh;
    logic [pcbi_pkg::CELL_W-1:0] burst, cell_new, res_cell;
    logic                        res_changed;

    function automatic logic [pcbi_pkg::CELL_W-1:0] absdiff(
        input logic [pcbi_pkg::CELL_W-1:0] a,
        input logic [pcbi_pkg::CELL_W-1:0] b
    );
        return (a > b) ? a - b : b - a;
    endfunction

    assign out_free = !r_o_valid || !i_out_stall;
    assign finish   = (r_state == pcbi_pkg::BS_LOOK) && out_free;

    // Burst from the largest colour difference
    always_comb begin
        diff_seen = (shadow_rdata != r_job.pixel);
        dr   = absdiff(shadow_rdata[23:16], r_job.pixel[23:16]);
        dg   = absdiff(shadow_rdata[15:8],  r_job.pixel[15:8]);
        db   = absdiff(shadow_rdata[7:0],   r_job.pixel[7:0]);
        dmax = dr;
        if (dg > dmax) dmax = dg;
        if (db > dmax) dmax = db;
        prod    = PROD_W'(dmax) * PROD_W'(r_job.gain);
        prod_sh = prod[PROD_W-1:8];
        burst   = (prod_sh > (PROD_W-8)'(pcbi_pkg::CELL_MAX))
                ? pcbi_pkg::CELL_MAX : prod_sh[pcbi_pkg::CELL_W-1:0];
        cell_new = (burst > cell_rdata) ? burst : cell_rdata;
    end

    // Result fields for the current job
    always_comb begin
        res_changed = 1'b0;
        res_cell    = '0;
        if (!r_job.oor) begin
            if (r_job.kind == pcbi_pkg::KIND_DRAIN) begin
                res_cell = cell_rdata;
            end else begin
                res_changed = diff_seen;
                if (r_job.cell_ok) res_cell = diff_seen ? cell_new : cell_rdata;
            end
        end
    end

    // Store write and read controls
    always_comb begin
        rd_en = (r_state == pcbi_pkg::BS_IDLE) && !i_empty;
        if (r_state == pcbi_pkg::BS_CLEAR) begin
            shadow_we    = 1'b1;
            shadow_waddr = r_clr_addr;
            shadow_wdata = pcbi_pkg::SHADOW_RESET;
            cell_we      = 1'b1;
            cell_waddr   = r_clr_addr;
            cell_wdata   = '0;
        end else begin
            shadow_waddr = r_job.si;
            shadow_wdata = r_job.pixel;
            cell_waddr   = r_job.ci;
            shadow_we    = finish && !r_job.oor && (r_job.kind == pcbi_pkg::KIND_UPDATE)
                         && diff_seen;
            if (r_job.kind == pcbi_pkg::KIND_DRAIN) begin
                cell_we    = finish && !r_job.oor;
                cell_wdata = '0;
            end else begin
                cell_we    = shadow_we && r_job.cell_ok && (burst > cell_rdata);
                cell_wdata = burst;
            end
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pcbi_pkg::BS_CLEAR:
                if (r_clr_addr == pcbi_pkg::ADDR_W'(pcbi_pkg::STORE_DEPTH - 1))
                    n_state = pcbi_pkg::BS_IDLE;
            pcbi_pkg::BS_IDLE: if (!i_empty) n_state = pcbi_pkg::BS_LOOK;
            pcbi_pkg::BS_LOOK: if (out_free) n_state = pcbi_pkg::BS_IDLE;
            default:           n_state = pcbi_pkg::BS_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        o_pop      = 1'b0;
        o_clearing = 1'b0;
        case (r_state)
            pcbi_pkg::BS_CLEAR: o_clearing = 1'b1;
            pcbi_pkg::BS_IDLE:  o_pop      = !i_empty;
            default: ;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= pcbi_pkg::BS_CLEAR;
            r_clr_addr <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == pcbi_pkg::BS_CLEAR) begin
                r_clr_addr <= r_clr_addr + pcbi_pkg::ADDR_W'(1);
            end
            if (finish)            r_o_valid <= 1'b1;
            else if (!i_out_stall) r_o_valid <= 1'b0;
        end
    end

    // Job capture and result register
    always_ff @(posedge i_clk) begin
        if (o_pop) r_job <= i_head;
        if (finish) begin
            r_o_changed <= res_changed;
            r_o_burst   <= res_changed ? burst : '0;
            r_o_cell    <= res_cell;
            r_o_oor     <= r_job.oor;
        end
    end

    pcbi_ram #(
        .WIDTH (pcbi_pkg::PIXEL_W),
        .DEPTH (pcbi_pkg::STORE_DEPTH)
    ) u_shadow (
        .i_clk   (i_clk),
        .i_we    (shadow_we),
        .i_waddr (shadow_waddr),
        .i_wdata (shadow_wdata),
        .i_re    (rd_en),
        .i_raddr (i_head.si),
        .o_rdata (shadow_rdata)
    );

    pcbi_ram #(
        .WIDTH (pcbi_pkg::CELL_W),
        .DEPTH (pcbi_pkg::STORE_DEPTH)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (cell_we),
        .i_waddr (cell_waddr),
        .i_wdata (cell_wdata),
        .i_re    (rd_en),
        .i_raddr (i_head.ci),
        .o_rdata (cell_rdata)
    );

    assign o_out_valid    = r_o_valid;
    assign o_changed      = r_o_changed;
    assign o_burst        = r_o_burst;
    assign o_cell_value   = r_o_cell;
    assign o_out_of_range = r_o_oor;

    // No job leaves the queue during the clearing pass
    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pcbi_pkg::BS_CLEAR) |-> !o_pop)
        else $error("job popped during clearing pass");

    // A flagged item never reports a change
    a_oor_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_oor) |-> (!r_o_changed && r_o_burst == '0 && r_o_cell == '0))
        else $error("out-of-range item reports data");

    // A non-zero burst comes only with a change
    a_burst_changed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_burst != '0) |-> r_o_changed)
        else $error("burst without change");

    // Store writes outside the clearing pass happen only as a job finishes
    a_write_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((shadow_we || cell_we) && r_state != pcbi_pkg::BS_CLEAR) |-> finish)
        else $error("store written outside job completion");

endmodule

// ===== hw/rtl/pixel_change_burst_injector.sv =====
// Top level of the pixel change burst injector: front, job queue and back.
// Depends on pcbi_pkg, pcbi_front, pcbi_fifo and pcbi_back.
//
//  channel   direction  handshake                   payload
//  input     in         i_in_valid / o_in_stall     i_kind i_pos_x i_pos_y i_new_pixel
//  result    out        o_out_valid / i_out_stall   o_changed o_burst o_cell_value
//                                                   o_out_of_range
//  config    in         i_cfg_we                    i_cfg_index i_cfg_data
//
// The front takes one item at a time (capture, reciprocal multiply, address multiply)
// and no new one until the last is pushed; the back reads the stores, then writes back.
// After reset a clearing pass writes all 262144 entries of both stores, one entry a
// cycle; items stall throughout, configuration writes are taken.
// A stalled result holds in the output register; the back reads the next job and waits
// with it until the result is taken, while the queue takes up to two more from the front.
module pixel_change_burst_injector (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pcbi_pkg::CIDX_W-1:0]   i_cfg_index,
    input  logic [pcbi_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_kind,
    input  logic [pcbi_pkg::PX_W-1:0]     i_pos_x,
    input  logic [pcbi_pkg::PX_W-1:0]     i_pos_y,
    input  logic [pcbi_pkg::PIXEL_W-1:0]  i_new_pixel,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_changed,
    output logic [pcbi_pkg::CELL_W-1:0]   o_burst,
    output logic [pcbi_pkg::CELL_W-1:0]   o_cell_value,
    output logic                          o_out_of_range
);

    pcbi_pkg::t_job push_job, head_job;
    logic           push, pop, empty, full, clearing;

    pcbi_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_hold      (clearing),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_kind      (i_kind),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_new_pixel (i_new_pixel),
        .i_full      (full),
        .o_push      (push),
        .o_job       (push_job)
    );

    pcbi_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_head  (head_job),
        .o_empty (empty),
        .o_full  (full)
    );

    pcbi_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head_job),
        .i_empty        (empty),
        .o_pop          (pop),
        .o_clearing     (clearing),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_changed      (o_changed),
        .o_burst        (o_burst),
        .o_cell_value   (o_cell_value),
        .o_out_of_range (o_out_of_range)
    );

endmodule

// ===== test/pcbi_burst_checker.sv =====
// Checker for the pixel change burst injector: watches the config port and both channels,
// predicts each result from its own shadow frame and cell plane, and counts mismatches.
// Depends on pcbi_pkg.
module pcbi_burst_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pcbi_pkg::CIDX_W-1:0]   i_cfg_index,
    input  logic [pcbi_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic                          i_kind,
    input  logic [pcbi_pkg::PX_W-1:0]     i_pos_x,
    input  logic [pcbi_pkg::PX_W-1:0]     i_pos_y,
    input  logic [pcbi_pkg::PIXEL_W-1:0]  i_new_pixel,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic                          i_changed,
    input  logic [pcbi_pkg::CELL_W-1:0]   i_burst,
    input  logic [pcbi_pkg::CELL_W-1:0]   i_cell_value,
    input  logic                          i_out_of_range,
    output int                            o_fail_count,
    output int                            o_pending
);
    import pcbi_pkg::*;

    typedef struct {
        logic              changed;
        logic [CELL_W-1:0] burst;
        logic [CELL_W-1:0] cell_value;
        logic              out_of_range;
    } t_burst_result;

    // Predictor state: written entries only, unwritten ones take their reset value
    logic [PIXEL_W-1:0] shadow_words [int];
    logic [CELL_W-1:0]  cell_plane [int];
    int unsigned        cfg_width, cfg_height, cfg_stride, cfg_cells_w, cfg_gain;

    t_burst_result burst_results_due [$];
    int            fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = burst_results_due.size();

    function automatic int unsigned chan_gap(logic [PIXEL_W-1:0] a, logic [PIXEL_W-1:0] b,
                                             int sh);
        int unsigned x, y;
        x = (a >> sh) & 8'hFF;
        y = (b >> sh) & 8'hFF;
        return (x > y) ? x - y : y - x;
    endfunction

    function automatic int unsigned cap(int unsigned v, int unsigned hi);
        return (v > hi) ? hi : v;
    endfunction

    // Work out the result of one word and advance the stores
    task automatic predict_burst(input t_kind kind, input int unsigned px,
                                 input int unsigned py, input logic [PIXEL_W-1:0] npx,
                                 output t_burst_result r);
        int unsigned w, h, sw, s, rows, si, ci, d, prod;
        logic [PIXEL_W-1:0] old;
        logic [CELL_W-1:0]  cur;
        logic cell_ok;
        w  = cap(cfg_width, MAX_WIDTH);
        h  = cap(cfg_height, MAX_HEIGHT);
        sw = cap(cfg_cells_w, MAX_WIDTH);
        s  = cap((cfg_stride == 0) ? 1 : cfg_stride, MAX_STRIDE);
        r  = '{1'b0, '0, '0, 1'b0};
        if (kind == KIND_DRAIN) begin
            rows = (h + s - 1) / s;
            if (px < sw && py < rows) begin
                ci = py * sw + px;
                r.cell_value = cell_plane.exists(ci) ? cell_plane[ci] : '0;
                cell_plane[ci] = '0;
            end else begin
                r.out_of_range = 1'b1;
            end
        end else if (px < w && py < h) begin
            si = py * w + px;
            cell_ok = (px / s) < sw;
            ci = cell_ok ? (py / s) * sw + px / s : 0;
            old = shadow_words.exists(si) ? shadow_words[si] : SHADOW_RESET;
            cur = cell_plane.exists(ci) ? cell_plane[ci] : '0;
            if (old != npx) begin
                d = chan_gap(old, npx, 16);
                if (chan_gap(old, npx, 8) > d) d = chan_gap(old, npx, 8);
                if (chan_gap(old, npx, 0) > d) d = chan_gap(old, npx, 0);
                prod = (d * cfg_gain) >> 8;
                r.burst = (prod > 255) ? CELL_MAX : prod[CELL_W-1:0];
                r.changed = 1'b1;
                shadow_words[si] = npx;
                if (cell_ok && r.burst > cur) begin
                    cur = r.burst;
                    cell_plane[ci] = cur;
                end
            end
            if (cell_ok) r.cell_value = cur;
        end else begin
            r.out_of_range = 1'b1;
        end
    endtask

    // Track config, predict accepted words and compare taken results
    always @(posedge i_clk) begin
        t_burst_result exp_r;
        int            errs;
        errs = 0;
        if (!i_rst_n) begin
            shadow_words.delete();
            cell_plane.delete();
            cfg_width   <= 512;
            cfg_height  <= 512;
            cfg_stride  <= 1;
            cfg_cells_w <= 512;
            cfg_gain    <= 256;
            burst_results_due.delete();
            fail_count  <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FRAME_WIDTH:   cfg_width   <= i_cfg_data;
                    CFG_FRAME_HEIGHT:  cfg_height  <= i_cfg_data;
                    CFG_SAMPLE_STRIDE: cfg_stride  <= i_cfg_data[STRIDE_W-1:0];
                    CFG_SAMPLED_WIDTH: cfg_cells_w <= i_cfg_data;
                    CFG_GAIN_Q8:       cfg_gain    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                predict_burst(t_kind'(i_kind), i_pos_x, i_pos_y, i_new_pixel, exp_r);
                burst_results_due.push_back(exp_r);
            end
            if (i_out_valid && !i_out_stall) begin
                if (burst_results_due.size() == 0) begin
                    $error("result word with nothing expected");
                    errs = errs + 1;
                end else begin
                    exp_r = burst_results_due.pop_front();
                    if (i_changed !== exp_r.changed) begin
                        $error("changed: expected %0d, got %0d", exp_r.changed, i_changed);
                        errs = errs + 1;
                    end
                    if (i_burst !== exp_r.burst) begin
                        $error("burst: expected %0d, got %0d", exp_r.burst, i_burst);
                        errs = errs + 1;
                    end
                    if (i_cell_value !== exp_r.cell_value) begin
                        $error("cell_value: expected %0d, got %0d",
                               exp_r.cell_value, i_cell_value);
                        errs = errs + 1;
                    end
                    if (i_out_of_range !== exp_r.out_of_range) begin
                        $error("out_of_range: expected %0d, got %0d",
                               exp_r.out_of_range, i_out_of_range);
                        errs = errs + 1;
                    end
                end
            end
            if (errs != 0) fail_count <= fail_count + errs;
        end
    end

endmodule

// ===== test/tb.sv =====
// Testbench top of the pixel change burst injector: clock, reset, stimulus and verdict.
// Depends on pcbi_pkg, pixel_change_burst_injector and pcbi_burst_checker.
module tb;
    import pcbi_pkg::*;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [CIDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]    cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic                kind = 1'b0;
    logic [PX_W-1:0]     pos_x = '0;
    logic [PX_W-1:0]     pos_y = '0;
    logic [PIXEL_W-1:0]  new_pixel = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                changed;
    logic [CELL_W-1:0]   burst;
    logic [CELL_W-1:0]   cell_value;
    logic                out_of_range;
    int                  fail_count;
    int                  pending;

    // Shared with the receiver: no-idle stretches and long hold-off requests
    logic                no_idle = 1'b0;
    int                  hold_requests = 0;
    int                  hold_served = 0;
    int                  stall_left = 0;

    // Geometry of the current phase, for shaping coordinates
    int unsigned         ph_w, ph_h, ph_s, ph_sw;
    logic [PIXEL_W-1:0]  palette [4];

    always #5 i_clk = ~i_clk;

    pixel_change_burst_injector dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_kind(kind), .i_pos_x(pos_x), .i_pos_y(pos_y), .i_new_pixel(new_pixel),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_changed(changed), .o_burst(burst), .o_cell_value(cell_value),
        .o_out_of_range(out_of_range)
    );

    pcbi_burst_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_kind(kind), .i_pos_x(pos_x), .i_pos_y(pos_y), .i_new_pixel(new_pixel),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_changed(changed), .i_burst(burst), .i_cell_value(cell_value),
        .i_out_of_range(out_of_range),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver: stall a random count after each taken word, or hold off on request
    always @(posedge i_clk) begin
        int n;
        if (hold_requests != hold_served) begin
            hold_served <= hold_requests;
            stall_left  <= 500;
            out_stall   <= 1'b1;
        end else if (out_valid && !out_stall) begin
            n = no_idle ? 0 : $urandom_range(0, 17);
            stall_left <= n;
            out_stall  <= (n > 0);
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            if (stall_left == 1) out_stall <= 1'b0;
        end
    end

    // Offer one word after a random gap (none in no-idle or back-to-back mode) and hold it until taken
    task automatic send_word(input t_kind k, input int unsigned x, input int unsigned y,
                             input logic [PIXEL_W-1:0] pix, input bit back_to_back);
        int n;
        n = (no_idle || back_to_back) ? 0 : $urandom_range(0, 17);
        if (n > 0) begin
            in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        in_valid  <= 1'b1;
        kind      <= k;
        pos_x     <= PX_W'(x);
        pos_y     <= PX_W'(y);
        new_pixel <= pix;
        do @(posedge i_clk); while (in_stall);
    endtask

    // Drop valid and wait until every expected word has arrived
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input int unsigned val);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(val);
    endtask

    // Load a geometry; register writes only while idle
    task automatic set_geometry(input int unsigned w, input int unsigned h,
                                input int unsigned s, input int unsigned sw,
                                input int unsigned g);
        int unsigned hh, ss;
        drain_results();
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
        write_reg(CFG_SAMPLE_STRIDE, s);
        write_reg(CFG_SAMPLED_WIDTH, sw);
        write_reg(CFG_GAIN_Q8, g);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        ss = (s[4:0] == 0) ? 1 : ((s[4:0] > 16) ? 16 : s[4:0]);
        ph_w  = (w > 512) ? 512 : w;
        hh    = (h > 512) ? 512 : h;
        ph_h  = hh;
        ph_s  = ss;
        ph_sw = (sw > 512) ? 512 : sw;
    endtask

    // One random word: mostly well-formed updates and drains, some noise
    task automatic random_word(input bit back_to_back);
        int r;
        int unsigned x, y, rows;
        logic [PIXEL_W-1:0] pix;
        r = $urandom_range(0, 99);
        rows = (ph_h + ph_s - 1) / ph_s;
        case ($urandom_range(0, 3))
            0:       pix = $urandom();
            1:       pix = palette[$urandom_range(0, 3)] ^ (32'h1 << $urandom_range(0, 31));
            default: pix = palette[$urandom_range(0, 3)];
        endcase
        if (r < 10) begin
            send_word(t_kind'($urandom_range(0, 1)), $urandom_range(0, 511),
                      $urandom_range(0, 511), $urandom(), back_to_back);
        end else if (r < 30) begin
            x = (ph_sw > 0) ? $urandom_range(0, ph_sw - 1 + (r & 1)) : 0;
            y = (rows > 0) ? $urandom_range(0, rows - 1 + ((r >> 1) & 1)) : 0;
            send_word(KIND_DRAIN, x, y, $urandom(), back_to_back);
        end else begin
            x = (ph_w > 0) ? $urandom_range(0, ph_w - 1) : 0;
            y = (ph_h > 0) ? $urandom_range(0, ph_h - 1) : 0;
            send_word(KIND_UPDATE, x, y, pix, back_to_back);
        end
    endtask

    // Stimulus
    initial begin
        int unsigned geo [8][5];
        geo = '{'{512, 512, 1, 512, 256}, '{1, 1, 1, 1, 0},
                '{16, 12, 3, 6, 300}, '{1023, 1023, 31, 1023, 1023},
                '{40, 30, 16, 3, 512}, '{7, 9, 0, 7, 100},
                '{0, 0, 0, 0, 512}, '{24, 20, 5, 2, 700}};
        palette = '{32'hFF000000, 32'h00FFFFFF, 32'h12345678, 32'hFF7F7F7F};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset geometry, unchanged, alpha only, full swing, corner drains
        set_geometry(512, 512, 1, 512, 256);
        send_word(KIND_UPDATE, 0, 0, 32'hFF000000, 0);
        send_word(KIND_UPDATE, 1, 0, 32'h00000000, 0);
        send_word(KIND_UPDATE, 511, 511, 32'h00FFFFFF, 0);
        send_word(KIND_UPDATE, 511, 511, 32'hFF808080, 0);
        send_word(KIND_DRAIN, 511, 511, 32'hFFFFFFFF, 0);
        send_word(KIND_DRAIN, 511, 511, 32'h0, 0);
        send_word(KIND_DRAIN, 0, 0, 32'h0, 0);
        // Cell column beyond the plane, frame bounds, drain past the rows, high gain
        set_geometry(3, 2, 2, 1, 512);
        send_word(KIND_UPDATE, 2, 0, 32'hFFFFFFFF, 0);
        send_word(KIND_UPDATE, 0, 1, 32'hFF200000, 0);
        send_word(KIND_UPDATE, 3, 0, 32'hFFFFFFFF, 0);
        send_word(KIND_UPDATE, 0, 2, 32'hFFFFFFFF, 0);
        send_word(KIND_DRAIN, 0, 1, 32'h0, 0);
        send_word(KIND_DRAIN, 1, 0, 32'h0, 0);
        send_word(KIND_DRAIN, 0, 0, 32'h0, 0);
        set_geometry(1023, 0, 31, 1023, 1023);
        send_word(KIND_UPDATE, 0, 0, 32'hFF010101, 0);
        send_word(KIND_DRAIN, 0, 0, 32'h0, 0);
        set_geometry(600, 512, 0, 600, 1023);
        send_word(KIND_UPDATE, 0, 0, 32'hFF010101, 0);
        send_word(KIND_UPDATE, 511, 0, 32'hFF0000FF, 0);
        send_word(KIND_DRAIN, 511, 0, 32'h0, 0);

        // Random phases across the geometry table
        for (int p = 0; p < 8; p++) begin
            set_geometry(geo[p][0], geo[p][1], geo[p][2], geo[p][3], geo[p][4]);
            no_idle <= (p % 4 == 3);
            for (int i = 0; i < 200; i++) begin
                // Hold off the receiver and keep offering so the block backs up
                if (p == 2 && i == 50) hold_requests <= hold_requests + 1;
                random_word(p == 2 && i >= 50 && i < 110);
                // Pause the sender until the block has fully emptied
                if (i == 120) begin
                    drain_results();
                end
            end
            no_idle <= 1'b0;
        end

        drain_results();
        if (fail_count == 0) begin
            $display("pixel_change_burst_injector regression: pass");
        end else begin
            $display("pixel_change_burst_injector regression: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #50000000;
        $display("pixel_change_burst_injector regression: fail");
        $finish;
    end

endmodule
